### hdl/tlnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlnf_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_LINE_END   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_CONTROL    = 3'd5;

	// Character codes
	localparam logic [7:0] CHR_TAB      = 8'h09;
	localparam logic [7:0] CHR_NL       = 8'h0A;
	localparam logic [7:0] CHR_SPACE    = 8'h20;
	localparam logic [7:0] CHR_DOLLAR   = 8'h24;
	localparam logic [7:0] CHR_CARET    = 8'h5E;
	localparam logic [3:0] CHR_DIGIT_HI = 4'h3;
	localparam logic [7:0] CARET_OFFSET = 8'd64;
	localparam logic [7:0] CTRL_MAX     = 8'd31;
	localparam logic [3:0] BCD_NINE     = 4'd9;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_file;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// What the back end has to emit for one input transaction
	typedef struct packed {
		logic       has_number;
		logic       has_dollar;
		logic       has_caret;
		logic [7:0] char_code;
	} job_ctl_t;

endpackage

`default_nettype wire

### hdl/tlnf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tlnf_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  tlnf_pkg::in_item_t                 in_item,
	input  wire                                cfg_we,
	input  wire [tlnf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire                                cfg_data,
	input  wire                                q_full,
	output logic                               push,
	output tlnf_pkg::job_ctl_t                 push_ctl,
	output logic [4*NUMBER_DIGITS-1:0]         push_digits,
	output logic [NUMBER_DIGITS-1:0]           push_lead
);

	localparam int CNT_W = 4 * NUMBER_DIGITS;

	logic number_all_q, number_nonblank_q, squeeze_blank_q;
	logic mark_line_end_q, show_tabs_q, show_control_q;

	logic             after_newline_q;
	logic             blank_seen_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic             an, bs;
	logic [CNT_W-1:0] cnt, cnt_inc, cnt_new;
	logic             is_nl, squeezed, numbered, tab_caret, ctl_caret;
	logic             carry;
	logic [3:0]       dig;
	logic [7:0]       c;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_all_q      <= 1'b0;
			number_nonblank_q <= 1'b0;
			squeeze_blank_q   <= 1'b0;
			mark_line_end_q   <= 1'b0;
			show_tabs_q       <= 1'b0;
			show_control_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tlnf_pkg::CFG_NUMBER_ALL:      number_all_q      <= cfg_data;
				tlnf_pkg::CFG_NUMBER_NONBLANK: number_nonblank_q <= cfg_data;
				tlnf_pkg::CFG_SQUEEZE_BLANK:   squeeze_blank_q   <= cfg_data;
				tlnf_pkg::CFG_MARK_LINE_END:   mark_line_end_q   <= cfg_data;
				tlnf_pkg::CFG_SHOW_TABS:       show_tabs_q       <= cfg_data;
				tlnf_pkg::CFG_SHOW_CONTROL:    show_control_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Apply start of file before classifying the byte
	assign an  = in_item.start_of_file ? 1'b1 : after_newline_q;
	assign bs  = in_item.start_of_file ? 1'b0 : blank_seen_q;
	assign cnt = in_item.start_of_file ? '0 : count_q;
	assign c   = in_item.in_byte;

	assign is_nl     = (c == tlnf_pkg::CHR_NL);
	assign squeezed  = squeeze_blank_q && an && is_nl && bs;
	assign numbered  = an && ((number_all_q && !number_nonblank_q)
	                   || (number_nonblank_q && !is_nl));
	assign tab_caret = show_tabs_q && (c == tlnf_pkg::CHR_TAB);
	assign ctl_caret = !tab_caret && show_control_q && (c <= tlnf_pkg::CTRL_MAX)
	                   && !is_nl && (c != tlnf_pkg::CHR_TAB);

	// Increment the decimal counter, hold it at all nines
	always_comb begin
		carry   = 1'b1;
		cnt_inc = cnt;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			dig = cnt[4*i +: 4];
			if (carry) begin
				if (dig == tlnf_pkg::BCD_NINE) begin
					cnt_inc[4*i +: 4] = 4'd0;
				end else begin
					cnt_inc[4*i +: 4] = dig + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (carry) begin
			cnt_inc = cnt;
		end
	end

	// A dropped blank line never advances the counter
	assign cnt_new = (numbered && !squeezed) ? cnt_inc : cnt;

	// Mark digits shown as spaces: zero with only zeros above, never the lowest
	always_comb begin
		push_lead = '0;
		for (int i = 1; i < NUMBER_DIGITS; i++) begin
			push_lead[i] = ((cnt_new >> (4 * i)) == '0);
		end
	end

	assign push                = accept && !squeezed;
	assign push_digits         = cnt_new;
	assign push_ctl.has_number = numbered;
	assign push_ctl.has_dollar = mark_line_end_q && is_nl;
	assign push_ctl.has_caret  = tab_caret || ctl_caret;
	assign push_ctl.char_code  = (tab_caret || ctl_caret) ? c + tlnf_pkg::CARET_OFFSET : c;

	// Advance line state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_newline_q <= 1'b1;
			blank_seen_q    <= 1'b0;
			count_q         <= '0;
		end else if (accept) begin
			count_q <= cnt_new;
			if (squeezed) begin
				after_newline_q <= 1'b1;
				blank_seen_q    <= bs;
			end else begin
				after_newline_q <= is_nl;
				blank_seen_q    <= an && is_nl;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/tlnf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tlnf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire [WIDTH-1:0]  push_data,
	output logic             full,
	input  wire              pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/tlnf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tlnf_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        head_valid,
	input  tlnf_pkg::job_ctl_t         head_ctl,
	input  wire [4*NUMBER_DIGITS-1:0]  head_digits,
	input  wire [NUMBER_DIGITS-1:0]    head_lead,
	output logic                       pop,
	output logic                       out_valid,
	input  wire                        out_stall,
	output tlnf_pkg::out_item_t        out_item
);

	localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

	localparam logic [2:0] PH_DIGIT  = 3'd0;
	localparam logic [2:0] PH_TAB    = 3'd1;
	localparam logic [2:0] PH_DOLLAR = 3'd2;
	localparam logic [2:0] PH_CARET  = 3'd3;
	localparam logic [2:0] PH_CHAR   = 3'd4;

	logic             started_q;
	logic [2:0]       phase_q;
	logic [DIG_W-1:0] digit_q;
	logic             out_valid_q;

	logic [2:0]       eff_phase, next_phase, phase_after_tab, phase_after_dollar;
	logic [DIG_W-1:0] eff_digit, next_digit;
	logic [7:0]       out_char;
	logic             last;
	logic             emit;

	assign phase_after_dollar = head_ctl.has_caret ? PH_CARET : PH_CHAR;
	assign phase_after_tab    = head_ctl.has_dollar ? PH_DOLLAR : phase_after_dollar;
	assign eff_phase = started_q ? phase_q
	                   : (head_ctl.has_number ? PH_DIGIT : phase_after_tab);
	assign eff_digit = started_q ? digit_q : DIG_W'(NUMBER_DIGITS - 1);

	// Select the byte for the current step and the step after it
	always_comb begin
		next_phase = PH_CHAR;
		next_digit = eff_digit;
		last       = 1'b0;
		unique case (eff_phase)
			PH_DIGIT: begin
				out_char = head_lead[eff_digit] ? tlnf_pkg::CHR_SPACE
				           : {tlnf_pkg::CHR_DIGIT_HI, head_digits[4*eff_digit +: 4]};
				if (eff_digit == '0) begin
					next_phase = PH_TAB;
				end else begin
					next_phase = PH_DIGIT;
					next_digit = eff_digit - 1'b1;
				end
			end
			PH_TAB: begin
				out_char   = tlnf_pkg::CHR_TAB;
				next_phase = phase_after_tab;
			end
			PH_DOLLAR: begin
				out_char   = tlnf_pkg::CHR_DOLLAR;
				next_phase = phase_after_dollar;
			end
			PH_CARET: begin
				out_char   = tlnf_pkg::CHR_CARET;
				next_phase = PH_CHAR;
			end
			default: begin
				out_char = head_ctl.char_code;
				last     = 1'b1;
			end
		endcase
	end

	assign emit = head_valid && (!out_valid_q || !out_stall);
	assign pop  = emit && last;

	// Step through the current transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			phase_q   <= PH_CHAR;
			digit_q   <= '0;
		end else if (emit) begin
			started_q <= !last;
			phase_q   <= next_phase;
			digit_q   <= next_digit;
		end
	end

	// Hold the output register while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item.out_byte    <= out_char;
			out_item.last_of_run <= last;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_pop_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !started_q)
		else $error("sequencer not restarted after pop");

	a_started_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> head_valid)
		else $error("transaction in progress without queue head");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(started_q && phase_q == PH_DIGIT) |-> (digit_q < DIG_W'(NUMBER_DIGITS - 1)))
		else $error("digit index out of range");

	a_no_emit_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled output dropped");
`endif

endmodule

`default_nettype wire

### hdl/text_line_number_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Text line filter: one raw byte in per transaction, zero or more bytes out.
// Input channel: in_valid / in_stall with in_item (byte and start_of_file).
// Output channel: out_valid / out_stall with out_item (byte and last_of_run);
// last_of_run marks the final output byte caused by one input byte.
// Configuration: cfg_we writes bit cfg_data into register cfg_index; write
// only while no transaction is in flight.
// The first output byte of an input passes through the queue entry and then
// the output register.
// Throughput: one input per cycle while each input yields one byte and the
// receiver does not stall. An input yielding n bytes, up to NUMBER_DIGITS+3,
// holds the output sequencer until its last byte; the two-entry queue then fills and in_stall rises.
// A squeezed blank line yields no output byte and is not queued.
// A stalled receiver holds the output register; the queue keeps accepting
// input until it is full.
// Reset clears all options, the line counter and the queue, and sets the
// line state as if a newline had just been seen.

module text_line_number_filter #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  tlnf_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  wire                            out_stall,
	output tlnf_pkg::out_item_t            out_item,
	input  wire                            cfg_we,
	input  wire [tlnf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire                            cfg_data
);

	localparam int JOB_W = $bits(tlnf_pkg::job_ctl_t) + 5 * NUMBER_DIGITS;

	logic                       q_full, push, pop, head_valid;
	tlnf_pkg::job_ctl_t         push_ctl, head_ctl;
	logic [4*NUMBER_DIGITS-1:0] push_digits, head_digits;
	logic [NUMBER_DIGITS-1:0]   push_lead, head_lead;
	logic [JOB_W-1:0]           head_data;

	tlnf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.push        (push),
		.push_ctl    (push_ctl),
		.push_digits (push_digits),
		.push_lead   (push_lead)
	);

	tlnf_queue #(
		.WIDTH(JOB_W),
		.DEPTH(tlnf_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_ctl, push_digits, push_lead}),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// Split the queue head into its fields
	assign {head_ctl, head_digits, head_lead} = head_data;

	tlnf_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_ctl    (head_ctl),
		.head_digits (head_digits),
		.head_lead   (head_lead),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule

`default_nettype wire

### tb/sv/tlnf_output_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the text line filter, predicts the emitted bytes
// and compares every output transaction with the oldest predicted byte.
module tlnf_output_checker #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	input  wire                           in_stall,
	input  tlnf_pkg::in_item_t            in_item,
	input  wire                           out_valid,
	input  wire                           out_stall,
	input  tlnf_pkg::out_item_t           out_item,
	input  wire                           cfg_we,
	input  wire [tlnf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire                           cfg_data,
	output int                            mismatches,
	output int                            bytes_pending
);

	// Options as last written
	logic opt_number_all;
	logic opt_number_nonblank;
	logic opt_squeeze_blank;
	logic opt_mark_line_end;
	logic opt_show_tabs;
	logic opt_show_control;

	// Line state of the filter
	logic                         at_line_start;
	logic                         prev_blank;
	logic [4*NUMBER_DIGITS-1:0]   line_bcd;

	tlnf_pkg::out_item_t expected_bytes[$];

	// Append the bytes one input transaction must produce
	task automatic filter_byte(input tlnf_pkg::in_item_t item);
		logic [7:0]                 c;
		logic                       is_nl;
		logic                       lead;
		logic                       carry;
		logic [3:0]                 digit;
		logic [4*NUMBER_DIGITS-1:0] next_bcd;
		c = item.in_byte;
		is_nl = (c == tlnf_pkg::CHR_NL);
		if (item.start_of_file) begin
			line_bcd = '0;
			at_line_start = 1'b1;
			prev_blank = 1'b0;
		end
		// Drop a repeated blank line entirely
		if (opt_squeeze_blank && at_line_start && is_nl && prev_blank)
			return;
		prev_blank = at_line_start && is_nl;
		if (at_line_start && ((opt_number_all && !opt_number_nonblank) ||
				(opt_number_nonblank && !is_nl))) begin
			// Advance the decimal counter, hold it once every digit is nine
			next_bcd = line_bcd;
			carry = 1'b1;
			for (int i = 0; i < NUMBER_DIGITS; i++) begin
				if (carry) begin
					if (next_bcd[4*i +: 4] == tlnf_pkg::BCD_NINE) begin
						next_bcd[4*i +: 4] = 4'd0;
					end else begin
						next_bcd[4*i +: 4] = next_bcd[4*i +: 4] + 4'd1;
						carry = 1'b0;
					end
				end
			end
			if (!carry)
				line_bcd = next_bcd;
			// Right-aligned number, leading zeros as spaces, then a tab
			lead = 1'b1;
			for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
				digit = line_bcd[4*i +: 4];
				if (digit != 4'd0 || i == 0)
					lead = 1'b0;
				expected_bytes.push_back('{out_byte: lead ? tlnf_pkg::CHR_SPACE
					: {tlnf_pkg::CHR_DIGIT_HI, digit}, last_of_run: 1'b0});
			end
			expected_bytes.push_back('{out_byte: tlnf_pkg::CHR_TAB, last_of_run: 1'b0});
		end
		if (opt_mark_line_end && is_nl)
			expected_bytes.push_back('{out_byte: tlnf_pkg::CHR_DOLLAR, last_of_run: 1'b0});
		if (opt_show_tabs && c == tlnf_pkg::CHR_TAB) begin
			expected_bytes.push_back('{out_byte: tlnf_pkg::CHR_CARET, last_of_run: 1'b0});
			c = tlnf_pkg::CHR_TAB + tlnf_pkg::CARET_OFFSET;
		end else if (opt_show_control && c <= tlnf_pkg::CTRL_MAX &&
				c != tlnf_pkg::CHR_NL && c != tlnf_pkg::CHR_TAB) begin
			expected_bytes.push_back('{out_byte: tlnf_pkg::CHR_CARET, last_of_run: 1'b0});
			c = c + tlnf_pkg::CARET_OFFSET;
		end
		expected_bytes.push_back('{out_byte: c, last_of_run: 1'b1});
		at_line_start = is_nl;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tlnf_pkg::out_item_t want;
		if (!arst_n) begin
			opt_number_all <= 1'b0;
			opt_number_nonblank <= 1'b0;
			opt_squeeze_blank <= 1'b0;
			opt_mark_line_end <= 1'b0;
			opt_show_tabs <= 1'b0;
			opt_show_control <= 1'b0;
			at_line_start = 1'b1;
			prev_blank = 1'b0;
			line_bcd = '0;
			expected_bytes.delete();
			mismatches = 0;
			bytes_pending <= 0;
		end else begin
			// Compare the output transaction with the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("out_byte: none expected, got %h", out_item.out_byte);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_item.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte,
							out_item.out_byte);
						mismatches++;
					end
					if (out_item.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %b, got %b", want.last_of_run,
							out_item.last_of_run);
						mismatches++;
					end
				end
			end
			// Predict from the input transaction
			if (in_valid && !in_stall)
				filter_byte(in_item);
			// Track option writes
			if (cfg_we) begin
				case (cfg_index)
					tlnf_pkg::CFG_NUMBER_ALL:      opt_number_all <= cfg_data;
					tlnf_pkg::CFG_NUMBER_NONBLANK: opt_number_nonblank <= cfg_data;
					tlnf_pkg::CFG_SQUEEZE_BLANK:   opt_squeeze_blank <= cfg_data;
					tlnf_pkg::CFG_MARK_LINE_END:   opt_mark_line_end <= cfg_data;
					tlnf_pkg::CFG_SHOW_TABS:       opt_show_tabs <= cfg_data;
					tlnf_pkg::CFG_SHOW_CONTROL:    opt_show_control <= cfg_data;
					default: ;
				endcase
			end
			bytes_pending <= expected_bytes.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int DIGITS = 6;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 8;
	localparam int COUNT_LINES = 101;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	tlnf_pkg::in_item_t             in_item;
	logic                           out_valid;
	logic                           out_stall;
	tlnf_pkg::out_item_t            out_item;
	logic                           cfg_we;
	logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic                           cfg_data;

	int mismatches;
	int bytes_pending;
	int tx_pct;
	int rx_pct;
	int hold_requests;

	text_line_number_filter #(.NUMBER_DIGITS(DIGITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tlnf_output_checker #(.NUMBER_DIGITS(DIGITS)) out_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.bytes_pending(bytes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int holds_done;
		holds_done = 0;
		out_stall <= 1'b0;
		forever begin
			if (hold_requests != holds_done) begin
				holds_done++;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end else begin
				out_stall <= ($urandom_range(99) < rx_pct);
				@(posedge clk);
			end
		end
	end

	// Offer one input transaction after random idle cycles, wait for acceptance
	task automatic send_byte(input logic [7:0] b, input logic sof);
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{in_byte: b, start_of_file: sof};
		do @(posedge clk); while (in_stall);
	endtask

	// Text-like bytes: many newlines and tabs, some control and high bytes
	function automatic tlnf_pkg::in_item_t random_text_byte();
		tlnf_pkg::in_item_t item;
		int                 pick;
		pick = $urandom_range(99);
		if (pick < 25)
			item.in_byte = tlnf_pkg::CHR_NL;
		else if (pick < 35)
			item.in_byte = tlnf_pkg::CHR_TAB;
		else if (pick < 47)
			item.in_byte = 8'($urandom_range(31));
		else if (pick < 82)
			item.in_byte = 8'($urandom_range(126, 32));
		else
			item.in_byte = 8'($urandom_range(255, 127));
		item.start_of_file = ($urandom_range(49) == 0);
		return item;
	endfunction

	// Drop valid, then wait for every predicted byte and the pipeline to empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (bytes_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tlnf_pkg::CFG_IDX_W-1:0] idx, input logic value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Bit positions follow the register indexes
	task automatic set_options(input logic [5:0] opts);
		write_reg(tlnf_pkg::CFG_NUMBER_ALL, opts[tlnf_pkg::CFG_NUMBER_ALL]);
		write_reg(tlnf_pkg::CFG_NUMBER_NONBLANK, opts[tlnf_pkg::CFG_NUMBER_NONBLANK]);
		write_reg(tlnf_pkg::CFG_SQUEEZE_BLANK, opts[tlnf_pkg::CFG_SQUEEZE_BLANK]);
		write_reg(tlnf_pkg::CFG_MARK_LINE_END, opts[tlnf_pkg::CFG_MARK_LINE_END]);
		write_reg(tlnf_pkg::CFG_SHOW_TABS, opts[tlnf_pkg::CFG_SHOW_TABS]);
		write_reg(tlnf_pkg::CFG_SHOW_CONTROL, opts[tlnf_pkg::CFG_SHOW_CONTROL]);
		cfg_we <= 1'b0;
	endtask

	initial begin
		tlnf_pkg::in_item_t item;
		logic [5:0]         opts;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= tlnf_pkg::CFG_NUMBER_ALL;
		cfg_data <= 1'b0;
		arst_n <= 1'b0;
		tx_pct = 0;
		rx_pct = 0;
		hold_requests = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every option on: nonblank numbering wins, blank runs squeezed
		set_options('1);
		send_byte(8'h41, 1'b1);
		send_byte(tlnf_pkg::CHR_NL, 1'b0);
		send_byte(tlnf_pkg::CHR_NL, 1'b0);
		send_byte(tlnf_pkg::CHR_NL, 1'b0);
		send_byte(tlnf_pkg::CHR_NL, 1'b0);
		send_byte(tlnf_pkg::CHR_TAB, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h1F, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(tlnf_pkg::CHR_NL, 1'b0);
		send_byte(8'h20, 1'b1);
		send_byte(tlnf_pkg::CHR_NL, 1'b0);
		wait_idle();

		// Number every line, show control bytes; a tab passes unchanged
		set_options(6'b100001);
		send_byte(tlnf_pkg::CHR_TAB, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(tlnf_pkg::CHR_NL, 1'b0);
		send_byte(tlnf_pkg::CHR_NL, 1'b0);
		send_byte(tlnf_pkg::CHR_NL, 1'b0);
		wait_idle();

		// Squeeze, mark line ends and show tabs; control bytes pass
		set_options(6'b011100);
		send_byte(tlnf_pkg::CHR_NL, 1'b1);
		send_byte(tlnf_pkg::CHR_NL, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(tlnf_pkg::CHR_TAB, 1'b0);
		wait_idle();

		// Random text under several option sets and idling mixes
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0)
				opts = '0;
			else if (p == 1)
				opts = '1;
			else
				opts = 6'($urandom_range(63));
			set_options(opts);
			case (p % 4)
				0: begin tx_pct = 0; rx_pct = 0; end
				1: begin tx_pct = 75; rx_pct = 0; end
				2: begin tx_pct = 0; rx_pct = 75; end
				default: begin tx_pct = 22; rx_pct = 22; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold off the receiver while the sender keeps offering
				if (p == 0 && n == 3)
					hold_requests <= hold_requests + 1;
				item = random_text_byte();
				send_byte(item.in_byte, item.start_of_file);
			end
			wait_idle();
		end

		// Long numbered run to carry the counter into three digits
		tx_pct = 0;
		rx_pct = 0;
		set_options(6'b001001);
		send_byte(tlnf_pkg::CHR_NL, 1'b1);
		for (int n = 1; n < COUNT_LINES; n++)
			send_byte(tlnf_pkg::CHR_NL, 1'b0);
		wait_idle();
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
